>>> rtl/cvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvn_pkg
// Shared widths, pipeline stage numbers, codes and types of the norm clipper.
// ----------------------------------------------------------------------------
package cvn_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int VEC_W         = 32;
   localparam int BOUND_W       = 31;
   localparam int SUM_W         = 2 * VEC_W;
   localparam int ROOT_W        = SUM_W / 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(65536);

   // pipeline stage numbers, stage 0 is the input register
   localparam int SUM_STAGE  = 2;
   localparam int ROOT_STAGE = SUM_STAGE + ROOT_W;
   localparam int FDIV_STAGE = ROOT_STAGE + 2;
   localparam int SEL_STAGE  = FDIV_STAGE + VEC_W;
   localparam int OUT_STAGE  = SEL_STAGE + 1;

   typedef enum logic {
      CMD_FORWARD  = 1'b0,
      CMD_BACKWARD = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_NORM_BOUND = 1'b0
   } csr_index_type;

   typedef struct packed {
      cmd_type cmd;
      logic    clip;
      logic    zero;
   } lane_ctrl_type;

endpackage

>>> rtl/cvn_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvn_delay
// Stallable shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module cvn_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

>>> rtl/cvn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvn_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cvn_div #(
   parameter int DVD_W = 63,
   parameter int DVS_W = 32,
   parameter int QUO_W = 32
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   logic [DVS_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] lo_ff  [QUO_W];
   logic [DVS_W-1:0] dvs_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [DVS_W-1:0] rem_src, dvs_src, rem_in;
      logic [QUO_W-1:0] lo_src, lo_in;
      logic [DVS_W:0]   rem_try;
      logic             ge;

      if (i == 0) begin : g_first
         assign rem_src = DVS_W'(dividend[DVD_W-1:QUO_W]);
         assign lo_src  = dividend[QUO_W-1:0];
         assign dvs_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign lo_src  = lo_ff[i-1];
         assign dvs_src = dvs_ff[i-1];
      end

      assign rem_try = {rem_src, lo_src[QUO_W-1]};
      assign ge      = rem_try >= {1'b0, dvs_src};
      assign rem_in  = ge ? DVS_W'(rem_try - {1'b0, dvs_src}) : rem_try[DVS_W-1:0];
      assign lo_in   = {lo_src[QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in;
            lo_ff[i]  <= lo_in;
            dvs_ff[i] <= dvs_src;
         end
      end
   end

   assign quotient = lo_ff[QUO_W-1];

endmodule

>>> rtl/cvn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cvn_sqrt (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [cvn_pkg::SUM_W-1:0]   radicand,
   output logic [cvn_pkg::ROOT_W-1:0]  root
);

   localparam int SW = cvn_pkg::SUM_W;
   localparam int RW = cvn_pkg::ROOT_W;
   localparam int EW = RW + 3;

   logic [SW-1:0] xs_ff   [RW];
   logic [EW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [SW-1:0] xs_src, xs_in;
      logic [EW-1:0] rem_src, rem_try, trial, rem_in;
      logic [RW-1:0] root_src, root_in;
      logic          ge;

      if (i == 0) begin : g_first
         assign xs_src   = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign xs_src   = xs_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      assign rem_try = {rem_src[EW-3:0], xs_src[SW-1 -: 2]};
      assign trial   = EW'({root_src, 2'b01});
      assign ge      = rem_try >= trial;
      assign rem_in  = ge ? rem_try - trial : rem_try;
      assign root_in = {root_src[RW-2:0], ge};
      assign xs_in   = {xs_src[SW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (adv) begin
            xs_ff[i]   <= xs_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

>>> rtl/cvn_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvn_lane
// One vector component: square, forward rescale and backward gradient.
// ----------------------------------------------------------------------------
module cvn_lane #(
   parameter int FRAC_BITS = cvn_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [cvn_pkg::VEC_W-1:0]     vec0,
   input  logic [cvn_pkg::VEC_W-1:0]     grad0,
   input  logic [cvn_pkg::BOUND_W-1:0]   bound,
   input  logic [cvn_pkg::SUM_W-1:0]     sum2,
   input  logic [cvn_pkg::ROOT_W-1:0]    root34,
   input  logic [FRAC_BITS:0]            ratio_a,
   input  cvn_pkg::lane_ctrl_type        ctrl,
   output logic [cvn_pkg::SUM_W-1:0]     sq1,
   output logic [cvn_pkg::VEC_W-1:0]     res
);

   localparam int F       = FRAC_BITS;
   localparam int VW      = cvn_pkg::VEC_W;
   localparam int SW      = cvn_pkg::SUM_W;
   localparam int RW      = cvn_pkg::ROOT_W;
   localparam int BW      = cvn_pkg::BOUND_W;
   localparam int A_W     = F + 1;
   localparam int PROD_W  = BW + VW;
   localparam int GP_W    = VW + A_W;
   localparam int A_STAGE = cvn_pkg::ROOT_STAGE + A_W;
   localparam int B_DLY   = A_STAGE - cvn_pkg::SUM_STAGE - F;
   localparam int M_DLY1  = cvn_pkg::ROOT_STAGE - 1;
   localparam int M_DLY2  = cvn_pkg::SEL_STAGE - cvn_pkg::ROOT_STAGE;
   localparam int G_DLY1  = A_STAGE;
   localparam int G_DLY2  = cvn_pkg::SEL_STAGE - A_STAGE - 1;
   localparam int Q_DLY   = cvn_pkg::SEL_STAGE - A_STAGE - 2;
   localparam logic [GP_W-1:0] HALF = GP_W'(1) << (F - 1);

   // magnitude and square
   logic [VW-1:0] m1_ff, gm1_ff;
   logic          vneg1_ff, gneg1_ff;
   logic [SW-1:0] sq1_ff, sq2_ff;

   function automatic logic [SW-1:0] m1_in_sq(input logic [VW-1:0] v);
      logic [VW-1:0] m;
      m = v[VW-1] ? VW'(-v) : v;
      return m * m;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= vec0[VW-1] ? VW'(-vec0) : vec0;
         vneg1_ff <= vec0[VW-1];
         gm1_ff   <= grad0[VW-1] ? VW'(-grad0) : grad0;
         gneg1_ff <= grad0[VW-1];
         sq1_ff   <= SW'(m1_in_sq(vec0));
         sq2_ff   <= sq1_ff;
      end
   end

   assign sq1 = sq1_ff;

   // b = (S - v^2) / S as a fraction
   logic [SW-1:0]  bnum;
   logic [F-1:0]   bq;
   logic           bzero;
   logic [A_W-1:0] b_full, b_sa;

   assign bnum = sum2 - sq2_ff;

   cvn_div #(.DVD_W(SW + F), .DVS_W(SW), .QUO_W(F)) u_bdiv (
      .clock(clock), .adv(adv), .dividend({bnum, F'(0)}), .divisor(sum2), .quotient(bq)
   );

   cvn_delay #(.WIDTH(1), .DEPTH(F)) u_bzero (
      .clock(clock), .adv(adv), .din(sq2_ff == '0), .dout(bzero)
   );

   assign b_full = bzero ? A_W'(1) << F : {1'b0, bq};

   cvn_delay #(.WIDTH(A_W), .DEPTH(B_DLY)) u_bdly (
      .clock(clock), .adv(adv), .din(b_full), .dout(b_sa)
   );

   // forward rescale K*v/n
   logic [VW:0]       mv34, mv68;
   logic [PROD_W-1:0] prod_ff;
   logic [RW-1:0]     n35_ff, n36_ff;
   logic [PROD_W-1:0] dvd_ff;
   logic [VW-1:0]     fq;

   cvn_delay #(.WIDTH(VW + 1), .DEPTH(M_DLY1)) u_mdly1 (
      .clock(clock), .adv(adv), .din({vneg1_ff, m1_ff}), .dout(mv34)
   );

   cvn_delay #(.WIDTH(VW + 1), .DEPTH(M_DLY2)) u_mdly2 (
      .clock(clock), .adv(adv), .din(mv34), .dout(mv68)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= bound * mv34[VW-1:0];
         n35_ff  <= root34;
         dvd_ff  <= prod_ff + PROD_W'(n35_ff >> 1);
         n36_ff  <= n35_ff;
      end
   end

   cvn_div #(.DVD_W(PROD_W), .DVS_W(RW), .QUO_W(VW)) u_fdiv (
      .clock(clock), .adv(adv), .dividend(dvd_ff), .divisor(n36_ff), .quotient(fq)
   );

   // backward gradient g*a*b
   logic [VW:0]       gv_p, gv68;
   logic [A_W-1:0]    p_ff;
   logic [2*A_W-1:0]  ab;
   logic [GP_W-1:0]   gp;
   logic [VW-1:0]     q_ff;
   logic              gneg_q_ff;
   logic [VW:0]       qv68;

   cvn_delay #(.WIDTH(VW + 1), .DEPTH(G_DLY1)) u_gdly1 (
      .clock(clock), .adv(adv), .din({gneg1_ff, gm1_ff}), .dout(gv_p)
   );

   cvn_delay #(.WIDTH(VW + 1), .DEPTH(G_DLY2)) u_gdly2 (
      .clock(clock), .adv(adv), .din(gv_p), .dout(gv68)
   );

   assign ab = ratio_a * b_sa;
   assign gp = gv_p[VW-1:0] * p_ff + HALF;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff      <= ab[F+A_W-1:F];
         q_ff      <= gp[F+VW-1:F];
         gneg_q_ff <= gv_p[VW];
      end
   end

   cvn_delay #(.WIDTH(VW + 1), .DEPTH(Q_DLY)) u_qdly (
      .clock(clock), .adv(adv), .din({gneg_q_ff, q_ff}), .dout(qv68)
   );

   // select
   logic [VW-1:0] vpass, gpass, fwd, bwd;

   assign vpass = mv68[VW] ? VW'(-mv68[VW-1:0]) : mv68[VW-1:0];
   assign gpass = gv68[VW] ? VW'(-gv68[VW-1:0]) : gv68[VW-1:0];
   assign fwd   = mv68[VW] ? VW'(-fq) : fq;
   assign bwd   = qv68[VW] ? VW'(-qv68[VW-1:0]) : qv68[VW-1:0];

   always_comb begin
      priority if (!ctrl.clip) begin
         res = (ctrl.cmd == cvn_pkg::CMD_BACKWARD) ? gpass : vpass;
      end else if (ctrl.zero) begin
         res = '0;
      end else begin
         res = (ctrl.cmd == cvn_pkg::CMD_BACKWARD) ? bwd : fwd;
      end
   end

endmodule

>>> rtl/clip_vector3_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_vector3_norm
// Clips a 3-vector to a norm bound, or scales its gradient, one word a cycle.
// throughput: one word per cycle, set by the fully pipelined 32-stage square
// root and 32-stage per-lane divider; a held result stalls the whole pipeline
// reset clears the valid pipeline and sets the bound to 1.0
// ----------------------------------------------------------------------------
module clip_vector3_norm #(
   parameter int FRAC_BITS = cvn_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // in_x, in_y, in_z, grad_x, grad_y, grad_z
   input  logic [6*cvn_pkg::VEC_W-1:0]        req_tdata,
   // cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x, out_y, out_z
   output logic [3*cvn_pkg::VEC_W-1:0]        rsp_tdata,
   // was_clipped
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cvn_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cvn_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cvn_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int VW  = cvn_pkg::VEC_W;
   localparam int BW  = cvn_pkg::BOUND_W;
   localparam int SW  = cvn_pkg::SUM_W;
   localparam int RW  = cvn_pkg::ROOT_W;
   localparam int A_W = FRAC_BITS + 1;
   localparam int OS  = cvn_pkg::OUT_STAGE;
   localparam int CW  = $bits(cvn_pkg::lane_ctrl_type);

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !reset;

   // register port
   logic [BW-1:0]   norm_bound_ff;
   logic [2*BW-1:0] kk_ff;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == cvn_pkg::CSR_NORM_BOUND);

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_bound_ff <= cvn_pkg::BOUND_RESET;
      end else if (csr_wr) begin
         norm_bound_ff <= csr_pwdata[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      kk_ff <= norm_bound_ff * norm_bound_ff;
   end

   assign csr_prdata = (csr_paddr[2] == cvn_pkg::CSR_NORM_BOUND) ?
                       cvn_pkg::CSR_DATA_W'(norm_bound_ff) : '0;

   // valid pipeline
   logic [OS:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[OS-1:0], req_tvalid};
      end
   end

   // input register
   logic [VW-1:0] v0_ff [3];
   logic [VW-1:0] g0_ff [3];
   logic          cmd0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd0_ff <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            v0_ff[i] <= req_tdata[i*VW +: VW];
            g0_ff[i] <= req_tdata[(i+3)*VW +: VW];
         end
      end
   end

   // merge: sum of squares, bound test, root, shared ratio
   logic [SW-1:0]  sq1 [3];
   logic [SW-1:0]  sum_ff;
   logic [RW-1:0]  root34;
   logic [A_W-1:0] ratio_a;
   logic           cmd2;
   cvn_pkg::lane_ctrl_type ctrl2, ctrl68;
   logic [CW-1:0]  ctrl68_bits;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sq1[0] + sq1[1] + sq1[2];
      end
   end

   cvn_delay #(.WIDTH(1), .DEPTH(cvn_pkg::SUM_STAGE)) u_cmd_dly (
      .clock(clock), .adv(adv), .din(cmd0_ff), .dout(cmd2)
   );

   assign ctrl2.cmd  = cvn_pkg::cmd_type'(cmd2);
   assign ctrl2.clip = sum_ff >= SW'(kk_ff);
   assign ctrl2.zero = (sum_ff == '0) || (norm_bound_ff == '0);

   cvn_delay #(.WIDTH(CW), .DEPTH(cvn_pkg::SEL_STAGE - cvn_pkg::SUM_STAGE)) u_ctrl_dly (
      .clock(clock), .adv(adv), .din(ctrl2), .dout(ctrl68_bits)
   );

   assign ctrl68 = ctrl68_bits;

   cvn_sqrt u_sqrt (
      .clock(clock), .adv(adv), .radicand(sum_ff), .root(root34)
   );

   cvn_div #(.DVD_W(BW + FRAC_BITS), .DVS_W(RW), .QUO_W(A_W)) u_adiv (
      .clock(clock), .adv(adv), .dividend({norm_bound_ff, FRAC_BITS'(0)}),
      .divisor(root34), .quotient(ratio_a)
   );

   // lanes
   logic [VW-1:0] res [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      cvn_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .adv(adv), .vec0(v0_ff[i]), .grad0(g0_ff[i]),
         .bound(norm_bound_ff), .sum2(sum_ff), .root34(root34), .ratio_a(ratio_a),
         .ctrl(ctrl68), .sq1(sq1[i]), .res(res[i])
      );
   end

   // output register
   logic [3*VW-1:0] rsp_tdata_ff;
   logic            rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {res[2], res[1], res[0]};
         rsp_tuser_ff <= ctrl68.clip;
      end
   end

   assign rsp_tvalid = vld_ff[OS];
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
